// ----- hw/rtl/lobm_pkg.sv -----
// Shared constants, codes and structs of the limit order book matcher.
package lobm_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int IDX_W       = $clog2(ORDER_SLOTS);
  localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
  localparam int RANK_W      = IDX_W;

  typedef enum logic [1:0] {
    REQ_NEW    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_AMEND  = 2'd2,
    REQ_RSVD   = 2'd3
  } lobm_req_t;

  typedef enum logic [3:0] {
    OC_TRADE     = 4'd0,
    OC_RESTED    = 4'd1,
    OC_FILLED    = 4'd2,
    OC_CANCELLED = 4'd3,
    OC_AMENDED   = 4'd4,
    OC_NOT_FOUND = 4'd5,
    OC_SIDE_MISM = 4'd6,
    OC_DUPLICATE = 4'd7,
    OC_BOOK_FULL = 4'd8
  } lobm_outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } lobm_state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_REMOVE,
    CMD_SET_QTY,
    CMD_WRITE
  } lobm_op_t;

  typedef struct packed {
    logic        side;
    logic [15:0] price;
    logic [31:0] key;
  } lobm_query_t;

  typedef struct packed {
    lobm_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] rank;
    logic [31:0]       qty;
    logic [31:0]       key;
    logic              side;
    logic [15:0]       price;
  } lobm_cmd_t;

  typedef struct packed {
    logic              best_found;
    logic [IDX_W-1:0]  best_idx;
    logic [15:0]       best_price;
    logic [RANK_W-1:0] best_rank;
    logic [31:0]       best_qty;
    logic [31:0]       best_key;
    logic              key_found;
    logic [IDX_W-1:0]  key_idx;
    logic              key_side;
    logic [15:0]       key_price;
    logic [31:0]       key_qty;
    logic [RANK_W-1:0] key_rank;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [CNT_W-1:0]  count;
  } lobm_link_t;

endpackage

// ----- hw/rtl/lobm_in_if.sv -----
// Request channel: valid/ready handshake with the request fields.
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        order_side;
  logic [15:0] limit_price;
  logic [31:0] order_quantity;
  logic [31:0] order_key;

  modport source (output valid, req_type, order_side, limit_price, order_quantity,
                  order_key, input ready);
  modport sink   (input valid, req_type, order_side, limit_price, order_quantity,
                  order_key, output ready);
endinterface

// ----- hw/rtl/lobm_out_if.sv -----
// Result channel: valid/ready handshake with trade and done fields.
interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] buy_id;
  logic [15:0] buy_limit;
  logic [31:0] sell_id;
  logic [15:0] sell_limit;
  logic [31:0] amount;
  logic [3:0]  outcome;
  logic        last;

  modport source (output valid, result_kind, buy_id, buy_limit, sell_id, sell_limit,
                  amount, outcome, last, input ready);
  modport sink   (input valid, result_kind, buy_id, buy_limit, sell_id, sell_limit,
                  amount, outcome, last, output ready);
endinterface

// ----- hw/rtl/lobm_cell.sv -----
// One book slot: holds a resting order and folds it into the scan chain.
module lobm_cell
  import lobm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  lobm_query_t      query,
  input  lobm_cmd_t        cmd,
  input  lobm_link_t       link_in,
  output lobm_link_t       link_out
);

  logic              valid_r;
  logic [31:0]       key_r;
  logic              side_r;
  logic [15:0]       price_r;
  logic [31:0]       qty_r;
  logic [RANK_W-1:0] rank_r;
  lobm_link_t        link_r;
  lobm_link_t        link_nxt;
  logic              hit;
  logic              crosses;
  logic              better;

  assign hit = (cmd.idx == my_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_REMOVE: begin
          if (hit) begin
            valid_r <= 1'b0;
          end else if (valid_r && rank_r > cmd.rank) begin
            rank_r <= rank_r - 1'b1;
          end
        end
        CMD_SET_QTY: begin
          if (hit) begin
            qty_r <= cmd.qty;
          end
        end
        CMD_WRITE: begin
          if (hit) begin
            valid_r <= 1'b1;
            key_r   <= cmd.key;
            side_r  <= cmd.side;
            price_r <= cmd.price;
            qty_r   <= cmd.qty;
            rank_r  <= cmd.rank;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    crosses = (query.side == 1'b0) ? (price_r <= query.price) : (price_r >= query.price);
    better  = 1'b0;
    if (valid_r && side_r != query.side && crosses) begin
      if (!link_in.best_found) begin
        better = 1'b1;
      end else if (price_r != link_in.best_price) begin
        better = (query.side == 1'b0) ? (price_r < link_in.best_price)
                                      : (price_r > link_in.best_price);
      end else begin
        better = rank_r < link_in.best_rank;
      end
    end

    link_nxt = link_in;
    if (better) begin
      link_nxt.best_found = 1'b1;
      link_nxt.best_idx   = my_idx;
      link_nxt.best_price = price_r;
      link_nxt.best_rank  = rank_r;
      link_nxt.best_qty   = qty_r;
      link_nxt.best_key   = key_r;
    end
    if (valid_r && key_r == query.key && !link_in.key_found) begin
      link_nxt.key_found = 1'b1;
      link_nxt.key_idx   = my_idx;
      link_nxt.key_side  = side_r;
      link_nxt.key_price = price_r;
      link_nxt.key_qty   = qty_r;
      link_nxt.key_rank  = rank_r;
    end
    if (!valid_r && !link_in.free_found) begin
      link_nxt.free_found = 1'b1;
      link_nxt.free_idx   = my_idx;
    end
    link_nxt.count = link_in.count + CNT_W'(valid_r);
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign link_out = link_r;

endmodule

// ----- hw/rtl/limit_order_book_matcher.sv -----
// Top level: request sequencer driving a chain of book slot cells.
//
// Requests (new, cancel, amend) enter on in_req; trades and one done item per
// request leave on out_res, both valid/ready channels. The book lives in a
// row of ORDER_SLOTS cells; one scan passes a search record down the row, one
// cell per cycle. A request costs one scan and one decide step per trade, and
// one more of each for the ending done item; a trade that fills the order is
// followed by the done item without a rescan, and an amend that moves the
// price adds one scan.
// One request is worked at a time; in_req.ready is high only between requests.
// Results sit in an output register; while the receiver stalls, the decide
// step holds and the book does not change. Reset (rst_n low, synchronous)
// empties the book and drops any request or result in flight.
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lobm_in_if.sink   in_req,
  lobm_out_if.source out_res
);

  lobm_state_t       state_r, state_nxt;
  lobm_req_t         type_r;
  logic              side_r;
  logic [15:0]       price_r;
  logic [31:0]       qty_r, qty_nxt;
  logic [31:0]       key_r;
  logic              reenter_r, reenter_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r;
  logic              ov_kind_r;
  logic [31:0]       ov_bid_r, ov_sid_r, ov_amt_r;
  logic [15:0]       ov_blim_r, ov_slim_r;
  lobm_outcome_t     ov_oc_r;
  logic              ov_last_r;

  logic              emit;
  logic              e_kind, e_last;
  logic [31:0]       e_bid, e_sid, e_amt;
  logic [15:0]       e_blim, e_slim;
  lobm_outcome_t     e_oc;
  logic              out_free;
  logic [31:0]       fill;

  lobm_query_t       query;
  lobm_cmd_t         cmd;
  lobm_link_t        links [ORDER_SLOTS+1];

  assign query.side  = side_r;
  assign query.price = price_r;
  assign query.key   = key_r;
  assign links[0]    = '0;

  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    lobm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (IDX_W'(i)),
      .query    (query),
      .cmd      (cmd),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  lobm_link_t res;
  assign res      = links[ORDER_SLOTS];
  assign out_free = !out_valid_r || out_res.ready;
  assign fill     = (res.best_qty < qty_r) ? res.best_qty : qty_r;

  assign in_req.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    qty_nxt     = qty_r;
    reenter_nxt = reenter_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.op      = CMD_NONE;
    emit        = 1'b0;
    e_kind      = 1'b1;
    e_last      = 1'b1;
    e_bid       = '0;
    e_sid       = '0;
    e_blim      = '0;
    e_slim      = '0;
    e_amt       = '0;
    e_oc        = OC_NOT_FOUND;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt   = ST_SCAN;
          qty_nxt     = in_req.order_quantity;
          reenter_nxt = 1'b0;
          cnt_nxt     = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ORDER_SLOTS - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          emit    = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_IDLE;
          if (type_r == REQ_NEW || reenter_r) begin
            if (qty_r == '0) begin
              e_oc = OC_FILLED;
            end else if (res.best_found) begin
              // trade against the best resting order, then rescan unless the order is filled
              e_kind = 1'b0;
              e_last = 1'b0;
              e_oc   = OC_TRADE;
              e_amt  = fill;
              if (side_r == 1'b0) begin
                e_bid = key_r;        e_blim = price_r;
                e_sid = res.best_key; e_slim = res.best_price;
              end else begin
                e_bid = res.best_key; e_blim = res.best_price;
                e_sid = key_r;        e_slim = price_r;
              end
              qty_nxt  = qty_r - fill;
              cmd.idx  = res.best_idx;
              cmd.rank = res.best_rank;
              if (res.best_qty == fill) begin
                cmd.op = CMD_REMOVE;
              end else begin
                cmd.op  = CMD_SET_QTY;
                cmd.qty = res.best_qty - fill;
              end
              state_nxt = (qty_r == fill) ? ST_DECIDE : ST_SCAN;
            end else if (res.key_found) begin
              e_oc  = OC_DUPLICATE;
              e_amt = qty_r;
            end else if (!res.free_found) begin
              e_oc  = OC_BOOK_FULL;
              e_amt = qty_r;
            end else begin
              e_oc      = OC_RESTED;
              e_amt     = qty_r;
              cmd.op    = CMD_WRITE;
              cmd.idx   = res.free_idx;
              cmd.rank  = RANK_W'(res.count);
              cmd.qty   = qty_r;
              cmd.key   = key_r;
              cmd.side  = side_r;
              cmd.price = price_r;
            end
            if (res.best_found && qty_r != '0 && qty_r == fill) begin
              // filled by this trade: the done item follows without a rescan
              qty_nxt = '0;
            end
          end else if (type_r == REQ_CANCEL) begin
            if (res.key_found) begin
              e_oc     = OC_CANCELLED;
              e_amt    = res.key_qty;
              cmd.op   = CMD_REMOVE;
              cmd.idx  = res.key_idx;
              cmd.rank = res.key_rank;
            end
          end else if (type_r == REQ_AMEND) begin
            if (res.key_found) begin
              cmd.idx  = res.key_idx;
              cmd.rank = res.key_rank;
              if (res.key_side != side_r) begin
                e_oc  = OC_SIDE_MISM;
                e_amt = res.key_qty;
              end else if (res.key_price == price_r) begin
                e_oc  = OC_AMENDED;
                e_amt = qty_r;
                if (qty_r == '0) begin
                  cmd.op = CMD_REMOVE;
                end else begin
                  cmd.op  = CMD_SET_QTY;
                  cmd.qty = qty_r;
                end
              end else begin
                // drop the old order and enter it again at the new price
                emit        = 1'b0;
                cmd.op      = CMD_REMOVE;
                reenter_nxt = 1'b1;
                state_nxt   = ST_SCAN;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    qty_r     <= qty_nxt;
    reenter_r <= reenter_nxt;
    cnt_r     <= cnt_nxt;
    if (in_req.valid && in_req.ready) begin
      type_r  <= lobm_req_t'(in_req.req_type);
      side_r  <= in_req.order_side;
      price_r <= in_req.limit_price;
      key_r   <= in_req.order_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ov_kind_r <= e_kind;
      ov_bid_r  <= e_bid;
      ov_blim_r <= e_blim;
      ov_sid_r  <= e_sid;
      ov_slim_r <= e_slim;
      ov_amt_r  <= e_amt;
      ov_oc_r   <= e_oc;
      ov_last_r <= e_last;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.result_kind = ov_kind_r;
  assign out_res.buy_id      = ov_bid_r;
  assign out_res.buy_limit   = ov_blim_r;
  assign out_res.sell_id     = ov_sid_r;
  assign out_res.sell_limit  = ov_slim_r;
  assign out_res.amount      = ov_amt_r;
  assign out_res.outcome     = ov_oc_r;
  assign out_res.last        = ov_last_r;

endmodule
